>>> hdl/assert_macros.svh
// Assertion macros shared by the blind motor controller RTL.
// Stand-alone header with no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on the rising clock edge, switched off while reset is low.
`define BMLC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked on every rising clock edge, reset cycles included.
`define BMLC_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/bmlc_pkg.sv
// Types, codes and reset constants for the blind motor limit controller.
// No dependencies; used by blind_motor_limit_controller.
package bmlc_pkg;

    // Controller phases, as reported on the phase output field.
    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_SETTLE   = 4'd1,
        PH_TRAVEL   = 4'd2,
        PH_LOOSEN   = 4'd3,
        PH_RELEASE  = 4'd4,
        PH_MSETTLE  = 4'd5,
        PH_MRUN     = 4'd6,
        PH_HANDOVER = 4'd7,
        PH_MLOOSEN  = 4'd8
    } phase_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_LOCKOUT       = 3'd0,
        CFG_CLOSE_TIMEOUT = 3'd1,
        CFG_OPEN_TIMEOUT  = 3'd2,
        CFG_SETTLE        = 3'd3,
        CFG_LOOSEN        = 3'd4,
        CFG_MANUAL_MIN    = 3'd5
    } cfg_index_t;

    // One tick beat; button_down sits in the lowest bit.
    typedef struct packed {
        logic close_request;
        logic open_request;
        logic limit_up;
        logic limit_down;
        logic button_up;
        logic button_down;
    } tick_t;

    // One result beat, padded to a byte; drive_left sits in the lowest bit.
    typedef struct packed {
        logic   spare;
        phase_t phase;
        logic   supply_pin;
        logic   drive_right;
        logic   drive_left;
    } result_t;

    // Configuration register set.
    typedef struct packed {
        logic [15:0] lockout;
        logic [15:0] close_timeout;
        logic [15:0] open_timeout;
        logic [9:0]  settle;
        logic [9:0]  loosen;
        logic [15:0] manual_min;
    } cfg_t;

    // Controller state. The phase counter never passes the settle or loosen
    // duration, so ten bits hold it.
    typedef struct packed {
        phase_t      phase;
        logic        dir_up;
        logic [9:0]  phase_ticks;
        logic [15:0] run_ticks;
        logic [15:0] since_trial;
    } state_t;

    // Outcome of one phase evaluation.
    typedef struct packed {
        state_t st;
        logic   again;
    } step_t;

    localparam cfg_t CfgReset = '{
        lockout:       16'd50000,
        close_timeout: 16'd11000,
        open_timeout:  16'd16000,
        settle:        10'd100,
        loosen:        10'd400,
        manual_min:    16'd1000
    };

    localparam state_t StateReset = '{
        phase:       PH_IDLE,
        dir_up:      1'b0,
        phase_ticks: 10'd0,
        run_ticks:   16'd0,
        since_trial: 16'd0
    };

    // The longest chain of phases passed within one tick is five long,
    // for example handover wait, settle, travel, loosen and release wait.
    localparam int StepPasses = 5;

endpackage

>>> hdl/blind_motor_limit_controller.sv
// Blind motor limit controller: one tick beat in, one result beat out.
// A tick beat accepted is held in the tick register, and its result beat is then registered
// in the result register and shown on m_tdata. Throughput: one beat per cycle while
// m_tready does not hold the result channel; the phase chain of a tick is settled by a
// short combinational step chain between the tick register and the result register.
// Reset (aresetn low, synchronous): phase idle, counters cleared, registers at
// their defaults, both channels empty. Depends on bmlc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module blind_motor_limit_controller (
    input  logic        aclk,
    input  logic        aresetn,
    // Tick channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata, from bit 0: button_down, button_up, limit_down, limit_up,
    // open_request, close_request, two unused bits.
    input  logic [7:0]  s_tdata,
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata, from bit 0: drive_left, drive_right, supply_pin, phase[3:0],
    // one zero bit.
    output logic [7:0]  m_tdata,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    logic               in_valid_reg;
    bmlc_pkg::tick_t    in_tick_reg;
    logic               out_valid_reg;
    bmlc_pkg::result_t  out_data_reg;
    bmlc_pkg::result_t  out_data_next;
    bmlc_pkg::state_t   state_reg;
    bmlc_pkg::state_t   state_next;
    bmlc_pkg::cfg_t     cfg_reg;
    logic               s_accept;
    logic               proc;

    // Enter a phase with its counter cleared.
    function automatic bmlc_pkg::state_t begin_phase(input bmlc_pkg::state_t s,
                                                     input bmlc_pkg::phase_t p);
        bmlc_pkg::state_t r;
        r = s;
        r.phase = p;
        r.phase_ticks = '0;
        return r;
    endfunction

    // Start an automatic trial in the given direction.
    function automatic bmlc_pkg::state_t start_auto(input bmlc_pkg::state_t s,
                                                    input logic up);
        bmlc_pkg::state_t r;
        r = s;
        r.dir_up = up;
        r.since_trial = '0;
        r.run_ticks = '0;
        return begin_phase(r, bmlc_pkg::PH_SETTLE);
    endfunction

    // One evaluation of the current phase; again asks for the next phase to
    // be evaluated within the same tick.
    function automatic bmlc_pkg::step_t bmlc_step(input bmlc_pkg::state_t s,
                                                  input bmlc_pkg::tick_t t,
                                                  input bmlc_pkg::cfg_t c);
        bmlc_pkg::step_t r;
        logic            lim;
        logic            held;
        logic            other;
        logic            expired;
        logic [15:0]     tmo;
        r.st = s;
        r.again = 1'b0;
        lim = s.dir_up ? t.limit_up : t.limit_down;
        held = s.dir_up ? t.button_up : t.button_down;
        other = s.dir_up ? t.button_down : t.button_up;
        expired = (s.since_trial >= c.lockout);
        tmo = s.dir_up ? c.open_timeout : c.close_timeout;
        case (s.phase)
            bmlc_pkg::PH_IDLE: begin
                if (t.open_request && !t.limit_up && expired) begin
                    r.st = start_auto(s, 1'b1);
                    r.again = 1'b1;
                end else if (t.close_request && !t.limit_down && expired) begin
                    r.st = start_auto(s, 1'b0);
                    r.again = 1'b1;
                end else if (t.button_down && !t.limit_down) begin
                    r.st.dir_up = 1'b0;
                    r.st.run_ticks = '0;
                    r.st = begin_phase(r.st, bmlc_pkg::PH_MSETTLE);
                    r.again = 1'b1;
                end else if (t.button_up && !t.limit_up) begin
                    r.st.dir_up = 1'b1;
                    r.st.run_ticks = '0;
                    r.st = begin_phase(r.st, bmlc_pkg::PH_MSETTLE);
                    r.again = 1'b1;
                end
            end
            bmlc_pkg::PH_SETTLE, bmlc_pkg::PH_MSETTLE: begin
                if (s.phase_ticks >= c.settle) begin
                    r.st = begin_phase(s, (s.phase == bmlc_pkg::PH_SETTLE) ?
                                          bmlc_pkg::PH_TRAVEL : bmlc_pkg::PH_MRUN);
                    r.again = 1'b1;
                end else begin
                    r.st.phase_ticks = s.phase_ticks + 10'd1;
                end
            end
            bmlc_pkg::PH_TRAVEL: begin
                if (!lim && (s.run_ticks < tmo) && !t.button_down && !t.button_up) begin
                    r.st.run_ticks = s.run_ticks + 16'd1;
                end else begin
                    r.st = begin_phase(s, bmlc_pkg::PH_LOOSEN);
                    r.again = 1'b1;
                end
            end
            bmlc_pkg::PH_LOOSEN: begin
                if (s.phase_ticks >= c.loosen) begin
                    r.st = begin_phase(s, bmlc_pkg::PH_RELEASE);
                    r.again = 1'b1;
                end else begin
                    r.st.phase_ticks = s.phase_ticks + 10'd1;
                end
            end
            bmlc_pkg::PH_RELEASE: begin
                if (!t.button_down && !t.button_up) begin
                    r.st = begin_phase(s, bmlc_pkg::PH_IDLE);
                end
            end
            bmlc_pkg::PH_MRUN: begin
                if (held && !lim) begin
                    if (other) begin
                        r.st.run_ticks = '0;
                        r.st = begin_phase(r.st, bmlc_pkg::PH_HANDOVER);
                    end else if (s.run_ticks != '1) begin
                        r.st.run_ticks = s.run_ticks + 16'd1;
                    end
                end else if (s.run_ticks >= c.manual_min) begin
                    r.st = begin_phase(s, bmlc_pkg::PH_MLOOSEN);
                    r.again = 1'b1;
                end else begin
                    r.st = begin_phase(s, bmlc_pkg::PH_IDLE);
                end
            end
            bmlc_pkg::PH_HANDOVER: begin
                if (other) begin
                    r.st.phase_ticks = '0;
                end else if (s.phase_ticks >= c.settle) begin
                    if (!lim) begin
                        r.st = start_auto(s, s.dir_up);
                        r.again = 1'b1;
                    end else begin
                        r.st = begin_phase(s, bmlc_pkg::PH_IDLE);
                    end
                end else begin
                    r.st.phase_ticks = s.phase_ticks + 10'd1;
                end
            end
            bmlc_pkg::PH_MLOOSEN: begin
                if (s.phase_ticks >= c.loosen) begin
                    r.st = begin_phase(s, bmlc_pkg::PH_IDLE);
                end else begin
                    r.st.phase_ticks = s.phase_ticks + 10'd1;
                end
            end
            default: begin
                r.st = begin_phase(s, bmlc_pkg::PH_IDLE);
            end
        endcase
        return r;
    endfunction

    // Handshakes: the tick register drains whenever the result register is
    // free or being emptied, so a beat can enter every cycle.
    assign proc     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Next state: age the trial lockout, then walk the phase chain of the tick.
    always_comb begin
        bmlc_pkg::step_t  stp;
        bmlc_pkg::state_t cur;
        logic             again;
        stp = '0;
        cur = state_reg;
        if (cur.since_trial != '1) begin
            cur.since_trial = cur.since_trial + 16'd1;
        end
        again = 1'b1;
        for (int i = 0; i < bmlc_pkg::StepPasses; i++) begin
            if (again) begin
                stp = bmlc_step(cur, in_tick_reg, cfg_reg);
                cur = stp.st;
                again = stp.again;
            end
        end
        state_next = cur;
    end

    // Outputs: motor lines and supply pin follow the phase the tick ends in.
    always_comb begin
        out_data_next = '0;
        out_data_next.supply_pin = 1'b1;
        out_data_next.phase = state_next.phase;
        case (state_next.phase)
            bmlc_pkg::PH_SETTLE, bmlc_pkg::PH_MSETTLE: begin
                out_data_next.supply_pin = 1'b0;
            end
            bmlc_pkg::PH_TRAVEL, bmlc_pkg::PH_MRUN, bmlc_pkg::PH_HANDOVER: begin
                out_data_next.supply_pin = 1'b0;
                out_data_next.drive_right = state_next.dir_up;
                out_data_next.drive_left = !state_next.dir_up;
            end
            bmlc_pkg::PH_LOOSEN, bmlc_pkg::PH_MLOOSEN: begin
                out_data_next.supply_pin = 1'b0;
                out_data_next.drive_left = state_next.dir_up;
                out_data_next.drive_right = !state_next.dir_up;
            end
            default: begin
                out_data_next.supply_pin = 1'b1;
            end
        endcase
    end

    // Control registers, controller state and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= bmlc_pkg::StateReset;
            cfg_reg       <= bmlc_pkg::CfgReset;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (proc) begin
                in_valid_reg <= 1'b0;
            end
            if (proc) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                case (cfg_index)
                    bmlc_pkg::CFG_LOCKOUT:       cfg_reg.lockout       <= cfg_wdata;
                    bmlc_pkg::CFG_CLOSE_TIMEOUT: cfg_reg.close_timeout <= cfg_wdata;
                    bmlc_pkg::CFG_OPEN_TIMEOUT:  cfg_reg.open_timeout  <= cfg_wdata;
                    bmlc_pkg::CFG_SETTLE:        cfg_reg.settle        <= cfg_wdata[9:0];
                    bmlc_pkg::CFG_LOOSEN:        cfg_reg.loosen        <= cfg_wdata[9:0];
                    bmlc_pkg::CFG_MANUAL_MIN:    cfg_reg.manual_min    <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Beat payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_tick_reg <= bmlc_pkg::tick_t'(s_tdata[5:0]);
        end
        if (proc) begin
            out_data_reg <= out_data_next;
        end
    end

    // Checks on the controller's own logic.
    `BMLC_ASSERT(a_no_short, aclk, aresetn, out_valid_reg |-> !(out_data_reg.drive_left && out_data_reg.drive_right), "both motor lines driven")
    `BMLC_ASSERT(a_drive_powered, aclk, aresetn, (out_valid_reg && (out_data_reg.drive_left || out_data_reg.drive_right)) |-> !out_data_reg.supply_pin, "motor driven with supply off")
    `BMLC_ASSERT(a_result_follows, aclk, aresetn, proc |=> out_valid_reg, "processed tick gave no result beat")
    `BMLC_ASSERT_RST(a_reset_clears, aclk, !aresetn |=> (!out_valid_reg && !in_valid_reg && (state_reg.phase == bmlc_pkg::PH_IDLE)), "reset left the controller busy")

endmodule
